[design/xo_pkg.sv]
// Package for the packet payload XOR obfuscator.
// Holds register indexes, protocol codes and the shared item types.
// No dependencies.
package xo_pkg;

	localparam int unsigned IPV6_HDR_BYTES = 40;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam logic [7:0] PROTO_GRE = 8'd47;

	localparam logic [15:0] GRE_IPV4 = 16'h0800;
	localparam logic [15:0] GRE_ALT  = 16'h0101;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ADDR_FAMILY = 3'd0,
		REG_KEY_LENGTH  = 3'd1,
		REG_FIRST_LIMIT = 3'd2,
		REG_KEY_WORD_0  = 3'd3,
		REG_KEY_WORD_1  = 3'd4,
		REG_KEY_WORD_2  = 3'd5,
		REG_KEY_WORD_3  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic        addr_family;
		logic [5:0]  key_length;
		logic [15:0] first_limit;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        out_last;
		logic        drop_packet;
		logic        checksum_valid;
		logic [15:0] checksum_value;
		logic [15:0] checksum_offset;
	} result_t;

	typedef struct packed {
		logic    held_vld;
		result_t held;
		logic    last_vld;
		result_t last;
	} push_t;

endpackage

[design/xo_cfg.sv]
// Configuration registers of the XOR obfuscator.
// Depends on xo_pkg.
module xo_cfg import xo_pkg::*; #(
	parameter int unsigned KEY_BYTES = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg,
	output logic [7:0]            key [KEY_BYTES]
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.addr_family <= 1'b0;
			cfg_q.key_length  <= 6'd1;
			cfg_q.first_limit <= 16'd0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ADDR_FAMILY: cfg_q.addr_family <= cfg_data[0];
				REG_KEY_LENGTH:  cfg_q.key_length  <= cfg_data[5:0];
				REG_FIRST_LIMIT: cfg_q.first_limit <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

	for (genvar i = 0; i < KEY_BYTES; i++) begin : g_key
		localparam logic [CFG_IDX_W-1:0] WIDX = CFG_IDX_W'(REG_KEY_WORD_0 + i / 8);
		logic [7:0] key_q;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				key_q <= 8'd0;
			end else if (cfg_we && cfg_index == WIDX) begin
				key_q <= cfg_data[(i % 8) * 8 +: 8];
			end
		end
		assign key[i] = key_q;
	end

endmodule

[design/xo_core.sv]
// Per-byte engine: input register, header parse, XOR, checksum and GRE swap.
// Depends on xo_pkg.
module xo_core import xo_pkg::*; #(
	parameter int unsigned KEY_BYTES  = 32,
	parameter int unsigned MAX_PACKET = 65535
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       in_offl,
	input  logic       room,
	input  cfg_t       cfg,
	input  logic [7:0] key [KEY_BYTES],
	output logic       push_en,
	output push_t      push
);

	localparam int unsigned KIW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       offl_s1;
	logic       adv;

	assign adv      = vld_s1 && room;
	assign in_ready = !vld_s1 || room;
	assign push_en  = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
			offl_s1 <= in_offl;
		end
	end

	logic [7:0]     held_q;
	logic           held_vld_q;
	logic [15:0]    pos_q;
	logic [5:0]     nhl_q;
	logic [7:0]     proto_q;
	logic [5:0]     thl_q;
	logic [15:0]    dpl_q;
	logic [15:0]    pc_q;
	logic [KIW-1:0] ki_q;
	logic [31:0]    sum_q;
	logic           gre_ok_q;
	logic           gre_nz_q;
	logic           ovl_q;

	logic [7:0]     b, held_n;
	logic [15:0]    pos_n, dpl_n, pc_n, t;
	logic [5:0]     nhl_n, thl_n, ihl4, dof4;
	logic [7:0]     proto_n;
	logic [KIW-1:0] ki_n;
	logic [31:0]    sum_n;
	logic           gre_ok_n, gre_nz_n, ovl_n;
	logic           in_hdr, in_range, tu, xor_it, proto_byte;
	logic [5:0]     kl, ck;
	logic [15:0]    w;

	always_comb begin
		kl = cfg.key_length;
		if (kl == 6'd0) kl = 6'd1;
		if ({1'b0, kl} > 7'(KEY_BYTES)) kl = 6'(KEY_BYTES);
	end

	assign ihl4 = {byte_s1[3:0], 2'b00};
	assign dof4 = {byte_s1[7:4], 2'b00};

	always_comb begin
		b          = byte_s1;
		held_n     = held_q;
		pos_n      = pos_q;
		nhl_n      = nhl_q;
		proto_n    = proto_q;
		thl_n      = thl_q;
		dpl_n      = dpl_q;
		pc_n       = pc_q;
		ki_n       = ki_q;
		sum_n      = sum_q;
		gre_ok_n   = gre_ok_q;
		gre_nz_n   = gre_nz_q;
		ovl_n      = ovl_q;
		in_hdr     = 1'b0;
		in_range   = 1'b0;
		xor_it     = 1'b0;
		proto_byte = 1'b0;
		t          = 16'd0;
		ck         = 6'd0;
		w          = {held_q, byte_s1};
		if ({1'b0, pos_q} >= 17'(MAX_PACKET)) begin
			ovl_n = 1'b1;
		end else begin
			if (pos_q == 16'd0)
				nhl_n = cfg.addr_family ? 6'(IPV6_HDR_BYTES)
					: ((ihl4 < 6'd20) ? 6'd20 : ihl4);
			in_hdr = pos_q < {10'd0, nhl_n};
			if (in_hdr) begin
				if (cfg.addr_family) begin
					if (pos_q == 16'd4) dpl_n[15:8] = byte_s1;
					if (pos_q == 16'd5) dpl_n[7:0] = byte_s1;
					proto_byte = pos_q == 16'd6;
					if (pos_q >= 16'd8) sum_n = sum_q + (pos_q[0] ? {24'd0, b} : {16'd0, b, 8'd0});
				end else begin
					proto_byte = pos_q == 16'd9;
					if (pos_q >= 16'd12 && pos_q < 16'd20)
						sum_n = sum_q + (pos_q[0] ? {24'd0, b} : {16'd0, b, 8'd0});
				end
				if (proto_byte) begin
					proto_n = byte_s1;
					case (byte_s1)
						PROTO_TCP: thl_n = 6'd20;
						PROTO_UDP: thl_n = 6'd8;
						PROTO_GRE: thl_n = 6'd4;
						default:   thl_n = 6'd0;
					endcase
				end
			end else begin
				t        = pos_q - {10'd0, nhl_n};
				in_range = !cfg.addr_family || t < dpl_q;
				if (proto_q == PROTO_TCP || proto_q == PROTO_UDP) begin
					if (proto_q == PROTO_TCP && t == 16'd12)
						thl_n = (dof4 < 6'd20) ? 6'd20 : dof4;
					xor_it = t >= {10'd0, thl_n} && in_range;
				end else if (proto_q == PROTO_GRE) begin
					if (t < 16'd2 && byte_s1 != 8'd0) gre_nz_n = 1'b1;
					if (t == 16'd3 && !gre_nz_q && (w == GRE_IPV4 || w == GRE_ALT)) begin
						gre_ok_n = 1'b1;
						held_n   = (w == GRE_IPV4) ? GRE_ALT[15:8] : GRE_IPV4[15:8];
						b        = (w == GRE_IPV4) ? GRE_ALT[7:0] : GRE_IPV4[7:0];
					end
					xor_it = gre_ok_n && t >= 16'd4 && in_range;
				end
				if (xor_it && (cfg.first_limit == 16'd0 || pc_q < cfg.first_limit)) begin
					b    = b ^ key[ki_q];
					ki_n = ({1'b0, 6'(ki_q)} + 7'd1 >= {1'b0, kl}) ? '0 : ki_q + 1'b1;
					pc_n = pc_q + 16'd1;
				end
				ck = (proto_q == PROTO_TCP) ? 6'd16 : 6'd6;
				if ((proto_q == PROTO_TCP || proto_q == PROTO_UDP) && in_range
						&& t != {10'd0, ck} && t != {10'd0, ck} + 16'd1)
					sum_n = sum_q + (pos_q[0] ? {24'd0, b} : {16'd0, b, 8'd0});
			end
			pos_n = pos_q + 16'd1;
		end
	end

	// end-of-packet checks and checksum fold
	logic        drop, cv;
	logic [15:0] plen, val, off;
	logic [31:0] s;
	logic [16:0] f1, f2;

	assign tu = proto_n == PROTO_TCP || proto_n == PROTO_UDP;

	always_comb begin
		drop = ovl_n || pos_n < {10'd0, nhl_n};
		plen = cfg.addr_family ? dpl_n : pos_n - {10'd0, nhl_n};
		if (!drop) begin
			if (tu) begin
				if (plen < {10'd0, thl_n}) drop = 1'b1;
				if (cfg.addr_family && {1'b0, pos_n} < {11'd0, nhl_n} + {1'b0, dpl_n})
					drop = 1'b1;
			end else if (proto_n == PROTO_GRE) begin
				if ({1'b0, pos_n} < {11'd0, nhl_n} + 17'd4) drop = 1'b1;
				if (cfg.addr_family && gre_ok_n && dpl_n < 16'd4) drop = 1'b1;
			end
		end
		cv  = tu && !drop && !offl_s1;
		s   = sum_n + {24'd0, proto_n} + {16'd0, plen};
		f1  = {1'b0, s[15:0]} + {1'b0, s[31:16]};
		f2  = {1'b0, f1[15:0]} + {16'd0, f1[16]};
		val = ~f2[15:0];
		if (proto_n == PROTO_UDP && val == 16'd0) val = 16'hFFFF;
		off = {10'd0, nhl_n} + ((proto_n == PROTO_TCP) ? 16'd16 : 16'd6);
		if (!cv) begin
			val = 16'd0;
			off = 16'd0;
		end
	end

	always_comb begin
		push.held_vld            = held_vld_q;
		push.held                = '0;
		push.held.out_byte       = held_n;
		push.last_vld            = last_s1;
		push.last.out_byte       = b;
		push.last.out_last       = 1'b1;
		push.last.drop_packet    = drop;
		push.last.checksum_valid = cv;
		push.last.checksum_value = val;
		push.last.checksum_offset = off;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= 8'd0;
			held_vld_q <= 1'b0;
			pos_q      <= 16'd0;
			nhl_q      <= 6'd0;
			proto_q    <= 8'd0;
			thl_q      <= 6'd0;
			dpl_q      <= 16'd0;
			pc_q       <= 16'd0;
			ki_q       <= '0;
			sum_q      <= 32'd0;
			gre_ok_q   <= 1'b0;
			gre_nz_q   <= 1'b0;
			ovl_q      <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				held_q     <= 8'd0;
				held_vld_q <= 1'b0;
				pos_q      <= 16'd0;
				nhl_q      <= 6'd0;
				proto_q    <= 8'd0;
				thl_q      <= 6'd0;
				dpl_q      <= 16'd0;
				pc_q       <= 16'd0;
				ki_q       <= '0;
				sum_q      <= 32'd0;
				gre_ok_q   <= 1'b0;
				gre_nz_q   <= 1'b0;
				ovl_q      <= 1'b0;
			end else begin
				held_q     <= b;
				held_vld_q <= 1'b1;
				pos_q      <= pos_n;
				nhl_q      <= nhl_n;
				proto_q    <= proto_n;
				thl_q      <= thl_n;
				dpl_q      <= dpl_n;
				pc_q       <= pc_n;
				ki_q       <= ki_n;
				sum_q      <= sum_n;
				gre_ok_q   <= gre_ok_n;
				gre_nz_q   <= gre_nz_n;
				ovl_q      <= ovl_n;
			end
		end
	end

endmodule

[design/xo_fifo.sv]
// Four-entry result queue taking up to two items a cycle.
// Depends on xo_pkg.
module xo_fifo import xo_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_en,
	input  push_t   push,
	output logic    room,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_item
);

	result_t    mem [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       pop;
	logic [1:0] npush;
	logic       both;

	assign room      = cnt_q <= 3'd2;
	assign out_valid = cnt_q != 3'd0;
	assign out_item  = mem[rp_q];
	assign pop       = out_valid && out_ready;
	assign both      = push.held_vld && push.last_vld;
	assign npush     = push_en ? (2'(push.held_vld) + 2'(push.last_vld)) : 2'd0;

	always_ff @(posedge clk) begin
		if (push_en) begin
			if (push.held_vld) mem[wp_q] <= push.held;
			if (both) mem[wp_q + 2'd1] <= push.last;
			else if (push.last_vld) mem[wp_q] <= push.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 2'd0;
			rp_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wp_q  <= wp_q + npush;
			rp_q  <= rp_q + 2'(pop);
			cnt_q <= cnt_q + {1'b0, npush} - 3'(pop);
		end
	end

endmodule

[design/packet_payload_xor_obfuscator.sv]
// Packet payload XOR obfuscator with TCP/UDP checksum rebuild: top level.
// Depends on xo_pkg, xo_cfg, xo_core and xo_fifo.
// Takes one packet byte per cycle, back to back, from the IP header on, while the queue
// has room. Each byte passes one input register and combinational parse/XOR/checksum
// logic, then a four-entry result queue; the last byte of a packet releases two items
// (the held byte and the final one) so the queue absorbs the extra item. Sustained
// rate is one item per cycle unless m_tready stalls; output lags input by one byte.
module packet_payload_xor_obfuscator import xo_pkg::*; #(
	parameter int unsigned KEY_BYTES  = 32,
	parameter int unsigned MAX_PACKET = 65535
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // data_byte
	input  logic                  s_tlast,
	input  logic                  s_tuser,   // checksum_offloaded
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [39:0]           m_tdata,   // out_byte, checksum_value, checksum_offset
	output logic                  m_tlast,
	output logic [1:0]            m_tuser    // drop_packet, checksum_valid
);

	cfg_t       cfg;
	logic [7:0] key [KEY_BYTES];
	logic       room, push_en;
	push_t      push;
	result_t    item;

	xo_cfg #(.KEY_BYTES(KEY_BYTES)) u_cfg (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .cfg, .key
	);

	xo_core #(.KEY_BYTES(KEY_BYTES), .MAX_PACKET(MAX_PACKET)) u_core (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready), .in_byte(s_tdata),
		.in_last(s_tlast), .in_offl(s_tuser),
		.room, .cfg, .key, .push_en, .push
	);

	xo_fifo u_fifo (
		.clk, .arst_n, .push_en, .push, .room,
		.out_valid(m_tvalid), .out_ready(m_tready), .out_item(item)
	);

	assign m_tdata = {item.checksum_offset, item.checksum_value, item.out_byte};
	assign m_tlast = item.out_last;
	assign m_tuser = {item.checksum_valid, item.drop_packet};

endmodule
